/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS_AT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");

// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPLY_AT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT_AT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_ALWAYS_AT(lbl, clk, rst, expr)
`define ASSERT_IMPLY_AT(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT_AT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/scd_pkg.sv */
// ---------------------------------------------------------------------------
// scd_pkg
// Widths, codes and serial unit command types for the sigma-clip threshold.
// ---------------------------------------------------------------------------
package scd_pkg;

   // batch size limit and the counter that holds 0..MAX_SAMPLES
   localparam int MAX_SAMPLES = 65536;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SAMPLES);

   // field and state widths
   localparam int DIST_W   = 32;
   localparam int MEAN_W   = 48;
   localparam int DEV_W    = 64;
   localparam int THR_W    = 32;
   localparam int SIGMA_W  = 16;
   localparam int SCOUNT_W = 17;
   localparam int WORK_W   = 64;
   localparam int OPND_W   = 32;

   // sigma reset value, -1.0 in Q8.8
   localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'hFF00;

   // request kinds
   localparam logic MODE_ACCUMULATE = 1'b0;
   localparam logic MODE_CHECK      = 1'b1;

   // register indexes
   localparam logic CSR_SIGMA        = 1'b0;
   localparam logic CSR_MAX_DISTANCE = 1'b1;

   // serial unit
   localparam int ALU_STEP_W = 7;
   localparam int ALU_REM_W  = 33;  // square root remainder, also holds divide remainder
   localparam logic [ALU_STEP_W-1:0] STEPS_MEAN_DIV = 7'd48;
   localparam logic [ALU_STEP_W-1:0] STEPS_VAR_DIV  = 7'd64;
   localparam logic [ALU_STEP_W-1:0] STEPS_MUL      = 7'd32;
   localparam logic [ALU_STEP_W-1:0] STEPS_SQRT     = 7'd32;

   typedef enum logic [2:0] {
      ALU_DIV  = 3'b001,
      ALU_MUL  = 3'b010,
      ALU_SQRT = 3'b100
   } alu_op_type;

   typedef struct packed {
      logic                  start;
      alu_op_type            op;
      logic [ALU_STEP_W-1:0] steps;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_status_type;

endpackage

/* sv/scd_serial_alu.sv */
// ---------------------------------------------------------------------------
// scd_serial_alu
// Shared bit-serial unit: restoring divide (one quotient bit per cycle),
// shift-add multiply (one multiplier bit per cycle) and digit-by-digit
// square root (two radicand bits per cycle).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scd_serial_alu
   import scd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  alu_cmd_type           cmd,
   input  logic [WORK_W-1:0]     operand_a,  // dividend, multiplier or radicand
   input  logic [OPND_W-1:0]     operand_b,  // divisor or multiplicand
   output alu_status_type        status,
   output logic [WORK_W-1:0]     result
);

   // control
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ALU_STEP_W-1:0] step_ff, step_in;
   alu_op_type            op_ff, op_in;

   // datapath shift registers
   logic [WORK_W-1:0]    work_ff, work_in;
   logic [ALU_REM_W-1:0] rem_ff, rem_in;
   logic [31:0]          root_ff, root_in;
   logic [OPND_W-1:0]    opnd_ff, opnd_in;

   // per-step terms
   logic [COUNT_W:0]     div_shift, div_diff, div_den;
   logic                 div_ge;
   logic [32:0]          mul_sum;
   logic [ALU_REM_W+1:0] sq_shift, sq_trial, sq_diff;
   logic                 sq_ge;
   logic                 last_step;

   always_comb begin
      div_den   = {1'b0, opnd_ff[COUNT_W-1:0]};
      div_shift = {rem_ff[COUNT_W-1:0], work_ff[WORK_W-1]};
      div_ge    = (div_shift >= div_den);
      div_diff  = div_shift - div_den;

      mul_sum = {1'b0, work_ff[WORK_W-1:32]} + (work_ff[0] ? {1'b0, opnd_ff} : 33'd0);

      sq_shift = {rem_ff, work_ff[WORK_W-1:WORK_W-2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      sq_ge    = (sq_shift >= sq_trial);
      sq_diff  = sq_shift - sq_trial;
   end

   // step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      op_in   = op_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      opnd_in = opnd_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = cmd.steps;
         op_in   = cmd.op;
         work_in = operand_a;
         rem_in  = '0;
         root_in = '0;
         opnd_in = operand_b;
      end else if (busy_ff) begin
         step_in = step_ff - ALU_STEP_W'(1);
         if (step_ff == ALU_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         unique case (op_ff)
            ALU_DIV: begin
               work_in = {work_ff[WORK_W-2:0], div_ge};
               rem_in  = div_ge ? ALU_REM_W'(div_diff[COUNT_W-1:0])
                                : ALU_REM_W'(div_shift[COUNT_W-1:0]);
            end
            ALU_MUL: begin
               work_in = {mul_sum, work_ff[31:1]};
            end
            ALU_SQRT: begin
               work_in = {work_ff[WORK_W-3:0], 2'b00};
               rem_in  = sq_ge ? sq_diff[ALU_REM_W-1:0] : sq_shift[ALU_REM_W-1:0];
               root_in = {root_ff[30:0], sq_ge};
            end
            default: begin
               work_in = work_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         op_ff   <= ALU_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         op_ff   <= op_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      opnd_ff <= opnd_in;
   end

   // result selection
   always_comb begin
      unique case (op_ff)
         ALU_SQRT: result = {32'd0, root_ff};
         default:  result = work_ff;
      endcase
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // final step of a running operation
   assign last_step = busy_ff && !cmd.start && (step_ff == ALU_STEP_W'(1));

   `ASSERT_IMPLY_AT(a_no_restart, clock, reset, cmd.start, !busy_ff)
   `ASSERT_NEXT_AT(a_last_step_done, clock, reset, last_step, done_ff && !busy_ff)
   `ASSERT_ALWAYS_AT(a_done_idle, clock, reset, !(done_ff && busy_ff))

endmodule

/* sv/sigma_clip_distance_threshold.sv */
// ---------------------------------------------------------------------------
// sigma_clip_distance_threshold
// Running mean/variance of squared distances with a sigma-clipped threshold.
// ---------------------------------------------------------------------------
// One request at a time goes through a shared bit-serial unit. A check
// request has its result registered once the result register is free, and
// the next request can be taken the cycle after that. An accumulate request
// runs a divide of the deviation by the running count for the mean update
// and then a multiply for the squared deviation term. A request marked last
// adds the batch close: a divide for the variance, a square root and a
// multiply by sigma; a single-sample batch skips the divide, and with
// negative sigma the close skips the serial unit and only clears the batch.
// Once the batch holds MAX_SAMPLES distances, further ones are dropped and
// their result goes out as for a check, but one marked last still closes the
// batch. Writing max_distance starts a squaring of the limit on the serial
// unit; no request or register write is taken until it is done. The result
// register lets a new request in while the previous result waits for
// rsp_tready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sigma_clip_distance_threshold
   import scd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] distance
   input  logic [1:0]  req_tuser,   // [0] mode, [1] index_valid
   input  logic        req_tlast,   // last
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] threshold, [48:32] sample_count, zero fill
   output logic [1:0]  rsp_tuser,   // [0] accepted, [1] threshold_unbounded
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,   // 0 sigma, 1 max_distance
   input  logic [31:0] csr_data
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_PREP   = 10'b00_0000_0010,
      ST_DIV    = 10'b00_0000_0100,
      ST_EMAG   = 10'b00_0000_1000,
      ST_MUL    = 10'b00_0001_0000,
      ST_CLOSE  = 10'b00_0010_0000,
      ST_FDIV   = 10'b00_0100_0000,
      ST_SQRT   = 10'b00_1000_0000,
      ST_SMUL   = 10'b01_0000_0000,
      ST_OUT    = 10'b10_0000_0000
   } state_type;

   // the limit squaring is tracked by its own state beside the main one
   typedef enum logic [1:0] {
      SQ_OFF  = 2'b01,
      SQ_BUSY = 2'b10
   } square_type;

   state_type  state_ff, state_in;
   square_type square_ff, square_in;

   // registers
   logic [SIGMA_W-1:0] sigma_ff, sigma_in;
   logic [DIST_W-1:0]  max_distance_ff, max_distance_in;
   logic [THR_W-1:0]   fixed_limit_ff, fixed_limit_in;

   // batch state
   logic [COUNT_W-1:0] batch_count_ff, batch_count_in;
   logic [MEAN_W-1:0]  mean_ff, mean_in;
   logic [DEV_W-1:0]   dev_sum_ff, dev_sum_in;
   logic [THR_W-1:0]   sigma_thr_ff, sigma_thr_in;

   // request held during processing
   logic              item_mode_ff, item_mode_in;
   logic [DIST_W-1:0] item_dist_ff, item_dist_in;
   logic              item_valid_ff, item_valid_in;
   logic              item_last_ff, item_last_in;
   logic [MEAN_W-1:0] dmag_ff, dmag_in;
   logic              up_ff, up_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_accepted_ff, rsp_accepted_in;
   logic [THR_W-1:0]    rsp_threshold_ff, rsp_threshold_in;
   logic                rsp_unbounded_ff, rsp_unbounded_in;
   logic [SCOUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // serial unit
   alu_cmd_type       alu_cmd;
   alu_status_type    alu_status;
   logic [WORK_W-1:0] alu_a, alu_result;
   logic [OPND_W-1:0] alu_b;

   // derived terms
   logic               req_fire, csr_fire;
   logic [MEAN_W-1:0]  d_wide, diff_up, diff_down, emag;
   logic               d_ge_mean;
   logic [COUNT_W-1:0] count_plus;
   logic [DEV_W:0]     dev_sum_ext;
   logic [MEAN_W-1:0]  thr_sum;
   logic               unbounded;
   logic [THR_W-1:0]   cur_thr;
   logic               out_free;

   scd_serial_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .cmd       (alu_cmd),
      .operand_a (alu_a),
      .operand_b (alu_b),
      .status    (alu_status),
      .result    (alu_result)
   );

   // handshakes
   assign csr_ready  = (state_ff == ST_IDLE) && (square_ff == SQ_OFF);
   assign req_tready = csr_ready && !csr_valid;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // distance against mean, both in Q32.16
   always_comb begin
      d_wide     = {item_dist_ff, 16'd0};
      d_ge_mean  = (d_wide >= mean_ff);
      diff_up    = d_wide - mean_ff;
      diff_down  = mean_ff - d_wide;
      emag       = d_ge_mean ? diff_up : diff_down;
      count_plus = batch_count_ff + COUNT_W'(1);
      dev_sum_ext = {1'b0, dev_sum_ff} + {17'd0, alu_result[WORK_W-1:16]};
      thr_sum    = {16'd0, mean_ff[MEAN_W-1:16]} + alu_result[MEAN_W-1:0];
   end

   // effective threshold
   always_comb begin
      unbounded = sigma_ff[SIGMA_W-1] && (max_distance_ff == '0);
      if (!sigma_ff[SIGMA_W-1]) begin
         cur_thr = sigma_thr_ff;
      end else if (unbounded) begin
         cur_thr = '1;
      end else begin
         cur_thr = fixed_limit_ff;
      end
   end

   // control and datapath sequencing
   always_comb begin
      state_in        = state_ff;
      square_in       = square_ff;
      sigma_in        = sigma_ff;
      max_distance_in = max_distance_ff;
      fixed_limit_in  = fixed_limit_ff;
      batch_count_in  = batch_count_ff;
      mean_in         = mean_ff;
      dev_sum_in      = dev_sum_ff;
      sigma_thr_in    = sigma_thr_ff;
      item_mode_in    = item_mode_ff;
      item_dist_in    = item_dist_ff;
      item_valid_in   = item_valid_ff;
      item_last_in    = item_last_ff;
      dmag_in         = dmag_ff;
      up_in           = up_ff;
      alu_cmd.start   = 1'b0;
      alu_cmd.op      = ALU_DIV;
      alu_cmd.steps   = STEPS_MEAN_DIV;
      alu_a           = '0;
      alu_b           = '0;

      // register writes; a new limit is squared on the serial unit
      if (csr_fire) begin
         unique case (csr_index)
            CSR_SIGMA: begin
               sigma_in = csr_data[SIGMA_W-1:0];
            end
            CSR_MAX_DISTANCE: begin
               max_distance_in = csr_data;
               square_in       = SQ_BUSY;
               alu_cmd.start   = 1'b1;
               alu_cmd.op      = ALU_MUL;
               alu_cmd.steps   = STEPS_MUL;
               alu_a           = {32'd0, csr_data};
               alu_b           = csr_data;
            end
            default: begin
               sigma_in = sigma_ff;
            end
         endcase
      end

      if ((square_ff == SQ_BUSY) && alu_status.done) begin
         square_in      = SQ_OFF;
         fixed_limit_in = (alu_result[WORK_W-1:48] != '0) ? '1 : alu_result[47:16];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_mode_in  = req_tuser[0];
               item_dist_in  = req_tdata;
               item_valid_in = req_tuser[1];
               item_last_in  = req_tlast;
               if (req_tuser[0] == MODE_CHECK) begin
                  state_in = ST_OUT;
               end else if (batch_count_ff >= COUNT_MAX) begin
                  state_in = req_tlast ? ST_CLOSE : ST_OUT;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         // bump count, take |d - mean| and divide it by the new count
         ST_PREP: begin
            batch_count_in = count_plus;
            dmag_in        = emag;
            up_in          = d_ge_mean;
            alu_cmd.start  = 1'b1;
            alu_cmd.op     = ALU_DIV;
            alu_cmd.steps  = STEPS_MEAN_DIV;
            alu_a          = {emag, 16'd0};
            alu_b          = OPND_W'(count_plus);
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            if (alu_status.done) begin
               mean_in  = up_ff ? (mean_ff + alu_result[MEAN_W-1:0])
                                : (mean_ff - alu_result[MEAN_W-1:0]);
               state_in = ST_EMAG;
            end
         end
         // deviation from the updated mean times the old one
         ST_EMAG: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = ALU_MUL;
            alu_cmd.steps = STEPS_MUL;
            alu_a         = {32'd0, emag[MEAN_W-1:16]};
            alu_b         = dmag_ff[MEAN_W-1:16];
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            if (alu_status.done) begin
               dev_sum_in = dev_sum_ext[DEV_W] ? '1 : dev_sum_ext[DEV_W-1:0];
               state_in   = item_last_ff ? ST_CLOSE : ST_OUT;
            end
         end
         // batch close
         ST_CLOSE: begin
            if (sigma_ff[SIGMA_W-1]) begin
               batch_count_in = '0;
               mean_in        = '0;
               dev_sum_in     = '0;
               state_in       = ST_OUT;
            end else if (batch_count_ff > COUNT_W'(1)) begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = ALU_DIV;
               alu_cmd.steps = STEPS_VAR_DIV;
               alu_a         = dev_sum_ff;
               alu_b         = OPND_W'(batch_count_ff - COUNT_W'(1));
               state_in      = ST_FDIV;
            end else begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = ALU_SQRT;
               alu_cmd.steps = STEPS_SQRT;
               alu_a         = '0;
               state_in      = ST_SQRT;
            end
         end
         ST_FDIV: begin
            if (alu_status.done) begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = ALU_SQRT;
               alu_cmd.steps = STEPS_SQRT;
               alu_a         = alu_result;
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (alu_status.done) begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = ALU_MUL;
               alu_cmd.steps = STEPS_MUL;
               alu_a         = {48'd0, sigma_ff};
               alu_b         = alu_result[31:0];
               state_in      = ST_SMUL;
            end
         end
         // mean plus sigma times std, saturated
         ST_SMUL: begin
            if (alu_status.done) begin
               sigma_thr_in   = (thr_sum[MEAN_W-1:THR_W] != '0) ? '1 : thr_sum[THR_W-1:0];
               batch_count_in = '0;
               mean_in        = '0;
               dev_sum_in     = '0;
               state_in       = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_accepted_in  = rsp_accepted_ff;
      rsp_threshold_in = rsp_threshold_ff;
      rsp_unbounded_in = rsp_unbounded_ff;
      rsp_count_in     = rsp_count_ff;
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_accepted_in  = (item_mode_ff == MODE_CHECK) && item_valid_ff &&
                            (unbounded || (item_dist_ff <= cur_thr));
         rsp_threshold_in = cur_thr;
         rsp_unbounded_in = unbounded;
         rsp_count_in     = SCOUNT_W'(batch_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         square_ff       <= SQ_OFF;
         sigma_ff        <= SIGMA_RESET;
         max_distance_ff <= '0;
         batch_count_ff  <= '0;
         mean_ff         <= '0;
         dev_sum_ff      <= '0;
         sigma_thr_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         square_ff       <= square_in;
         sigma_ff        <= sigma_in;
         max_distance_ff <= max_distance_in;
         batch_count_ff  <= batch_count_in;
         mean_ff         <= mean_in;
         dev_sum_ff      <= dev_sum_in;
         sigma_thr_ff    <= sigma_thr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      fixed_limit_ff   <= fixed_limit_in;
      item_mode_ff     <= item_mode_in;
      item_dist_ff     <= item_dist_in;
      item_valid_ff    <= item_valid_in;
      item_last_ff     <= item_last_in;
      dmag_ff          <= dmag_in;
      up_ff            <= up_in;
      rsp_accepted_ff  <= rsp_accepted_in;
      rsp_threshold_ff <= rsp_threshold_in;
      rsp_unbounded_ff <= rsp_unbounded_in;
      rsp_count_ff     <= rsp_count_in;
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_threshold_ff};
   assign rsp_tuser  = {rsp_unbounded_ff, rsp_accepted_ff};

   `ASSERT_ALWAYS_AT(a_count_bound, clock, reset, batch_count_ff <= COUNT_MAX)
   `ASSERT_IMPLY_AT(a_unbounded_ones, clock, reset, rsp_valid_ff && rsp_unbounded_ff, rsp_threshold_ff == '1)
   `ASSERT_NEXT_AT(a_out_loads, clock, reset, (state_ff == ST_OUT) && out_free, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
